### design/alternating_rle_table_decoder_macros.svh
// ----------------------------------------------------------------------------
// alternating_rle_table_decoder_macros.svh
// Assertion macros shared by the decoder checker. The clock is clk and the
// reset is arst_n in the scope where these macros are used.
// ----------------------------------------------------------------------------
`ifndef ALTERNATING_RLE_TABLE_DECODER_MACROS_SVH
`define ALTERNATING_RLE_TABLE_DECODER_MACROS_SVH

// same-cycle or multi-cycle property, checked outside reset
`define ARTD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("artd assertion failed");

// cause in this cycle, effect in the next
`define ARTD_ASSERT_NEXT(lbl, cause, effect) \
	`ARTD_ASSERT(lbl, (cause) |=> (effect))

`endif

### design/artd_pkg.sv
// ----------------------------------------------------------------------------
// artd_pkg
// Types and constants of the alternating literal/run table decoder.
// ----------------------------------------------------------------------------
package artd_pkg;

	localparam int MAX_RUN_DEF = 64;
	localparam logic [16:0] TABLE_DEPTH = 17'd65536;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 17;
	localparam logic [CFG_IDX_W-1:0] CFG_WORDS_PER_ELEMENT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_ENTRIES = 1'b1;

	// word phase codes
	localparam logic [1:0] PH_COUNT = 2'd0;
	localparam logic [1:0] PH_TYPE = 2'd1;
	localparam logic [1:0] PH_VALUE = 2'd2;

	localparam logic [1:0] WPE_TWO = 2'd2;

	typedef struct packed {
		logic action;
		logic signed [31:0] stream_word;
	} in_t;

	typedef struct packed {
		logic signed [31:0] entry_type;
		logic signed [31:0] entry_value;
		logic [15:0] entry_index;
		logic last;
		logic table_done;
		logic run_clamped;
	} out_t;

	// result handed from the sequencer to the output register
	typedef struct packed {
		logic vld;
		out_t res;
	} emit_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN = 2'b10
	} state_t;

endpackage

### design/artd_oreg.sv
// ----------------------------------------------------------------------------
// artd_oreg
// Output register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module artd_oreg (
	input  logic clk,
	input  logic arst_n,
	input  artd_pkg::emit_t emit,
	output logic free,
	output logic out_valid,
	input  logic out_ready,
	output artd_pkg::out_t out_data
);

	logic vld_q;
	artd_pkg::out_t data_q;

	assign free = !vld_q || out_ready;
	assign out_valid = vld_q;
	assign out_data = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (free) begin
			vld_q <= emit.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (free && emit.vld) begin
			data_q <= emit.res;
		end
	end

endmodule

### design/artd_seq.sv
// ----------------------------------------------------------------------------
// artd_seq
// Decode sequencer: group/phase tracking, configuration registers and the shared
// index incrementer that also expands a run, one element per cycle unless stalled.
// ----------------------------------------------------------------------------
module artd_seq #(
	parameter int MAX_RUN = artd_pkg::MAX_RUN_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  artd_pkg::in_t in_data,
	input  logic cfg_we,
	input  logic [artd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [artd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic free,
	output artd_pkg::emit_t emit
);

	localparam int RUN_W = $clog2(MAX_RUN + 1);

	artd_pkg::state_t state_q;
	logic [1:0] wpe_q;
	logic [16:0] total_q;
	logic mode_q;
	logic [1:0] phase_q;
	logic [30:0] rem_q;
	logic [16:0] idx_q;
	logic signed [31:0] held_q;
	logic [RUN_W-1:0] cnt_q;
	logic signed [31:0] rtype_q;
	logic signed [31:0] rval_q;
	logic rclamp_q;

	logic [16:0] lim;
	logic two;
	logic [1:0] elem_phase;
	logic [16:0] idx_nxt;
	logic done_nxt;
	logic in_acc;
	logic [30:0] cnt_word;
	logic signed [31:0] cur_type;
	logic clamp;
	logic run_last;

	assign lim = (total_q > artd_pkg::TABLE_DEPTH) ? artd_pkg::TABLE_DEPTH : total_q;
	assign two = (wpe_q == artd_pkg::WPE_TWO);
	assign elem_phase = two ? artd_pkg::PH_TYPE : artd_pkg::PH_VALUE;
	// shared incrementer and limit compare
	assign idx_nxt = idx_q + 17'd1;
	assign done_nxt = (idx_nxt >= lim);
	assign in_ready = (state_q == artd_pkg::ST_IDLE) && free;
	assign in_acc = in_valid && in_ready;
	assign cnt_word = in_data.stream_word[31] ? 31'd0 : in_data.stream_word[30:0];
	assign cur_type = two ? held_q : 32'sd0;
	assign clamp = (rem_q > 31'(MAX_RUN));
	assign run_last = (cnt_q == RUN_W'(1)) || done_nxt;

	always_comb begin
		emit = '0;
		unique case (state_q)
			artd_pkg::ST_IDLE: begin
				if (in_acc && !in_data.action) begin
					if (idx_q >= lim) begin
						// word after completion: status word only
						emit.vld = 1'b1;
						emit.res.entry_index = idx_q[16] ? 16'hFFFF : idx_q[15:0];
						emit.res.last = 1'b1;
						emit.res.table_done = 1'b1;
					end else if (phase_q != artd_pkg::PH_COUNT && phase_q != artd_pkg::PH_TYPE
						&& !mode_q) begin
						emit.vld = 1'b1;
						emit.res.entry_type = cur_type;
						emit.res.entry_value = in_data.stream_word;
						emit.res.entry_index = idx_q[15:0];
						emit.res.last = 1'b1;
						emit.res.table_done = done_nxt;
					end
				end
			end
			artd_pkg::ST_RUN: begin
				if (free) begin
					emit.vld = 1'b1;
					emit.res.entry_type = rtype_q;
					emit.res.entry_value = rval_q;
					emit.res.entry_index = idx_q[15:0];
					emit.res.last = run_last;
					emit.res.table_done = done_nxt;
					emit.res.run_clamped = rclamp_q;
				end
			end
			default: begin
				emit = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpe_q <= 2'd1;
			total_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				artd_pkg::CFG_WORDS_PER_ELEMENT: wpe_q <= cfg_data[1:0];
				artd_pkg::CFG_TOTAL_ENTRIES: total_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= artd_pkg::ST_IDLE;
			mode_q <= 1'b0;
			phase_q <= artd_pkg::PH_COUNT;
			rem_q <= '0;
			idx_q <= '0;
			held_q <= '0;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				artd_pkg::ST_IDLE: begin
					if (in_acc) begin
						if (in_data.action) begin
							mode_q <= 1'b0;
							phase_q <= artd_pkg::PH_COUNT;
							rem_q <= '0;
							idx_q <= '0;
							held_q <= '0;
						end else if (idx_q >= lim) begin
							// ignored word
						end else if (phase_q == artd_pkg::PH_COUNT) begin
							rem_q <= cnt_word;
							if (!mode_q && cnt_word == 31'd0) begin
								mode_q <= 1'b1;
							end else begin
								phase_q <= elem_phase;
							end
						end else if (phase_q == artd_pkg::PH_TYPE) begin
							held_q <= in_data.stream_word;
							phase_q <= artd_pkg::PH_VALUE;
						end else if (!mode_q) begin
							idx_q <= idx_nxt;
							rem_q <= rem_q - 31'd1;
							if (rem_q == 31'd1) begin
								mode_q <= 1'b1;
								phase_q <= artd_pkg::PH_COUNT;
							end else begin
								phase_q <= elem_phase;
							end
						end else begin
							// run element: expand over the following cycles
							cnt_q <= clamp ? RUN_W'(MAX_RUN) : rem_q[RUN_W-1:0];
							rem_q <= '0;
							mode_q <= 1'b0;
							phase_q <= artd_pkg::PH_COUNT;
							if (rem_q != 31'd0) begin
								state_q <= artd_pkg::ST_RUN;
							end
						end
					end
				end
				artd_pkg::ST_RUN: begin
					if (free) begin
						idx_q <= idx_nxt;
						cnt_q <= cnt_q - RUN_W'(1);
						if (run_last) begin
							state_q <= artd_pkg::ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= artd_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && phase_q == artd_pkg::PH_VALUE && mode_q) begin
			rtype_q <= cur_type;
			rval_q <= in_data.stream_word;
			rclamp_q <= clamp;
		end
	end

endmodule

### design/alternating_rle_table_decoder.sv
// ----------------------------------------------------------------------------
// alternating_rle_table_decoder
// Literal/run table decoder: count, type and value words in, table elements
// out with their index, stopping at the configured total.
// ----------------------------------------------------------------------------
// Count, type and literal words can be taken back to back; a literal result is
// registered at acceptance and shows on the next cycle.
// A run element expands into n elements (n = elements emitted, at most MAX_RUN):
// the shared index incrementer emits one element per cycle, input not ready.
// Output stalls hold the block. Reset (arst_n low) clears decode state,
// sets words_per_element to 1 and total_entries to 0.
module alternating_rle_table_decoder #(
	parameter int MAX_RUN = artd_pkg::MAX_RUN_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  artd_pkg::in_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output artd_pkg::out_t out_data,
	input  logic cfg_we,
	input  logic [artd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [artd_pkg::CFG_DATA_W-1:0] cfg_data
);

	artd_pkg::emit_t emit;
	logic free;

	artd_seq #(
		.MAX_RUN(MAX_RUN)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.free(free),
		.emit(emit)
	);

	artd_oreg u_oreg (
		.clk(clk),
		.arst_n(arst_n),
		.emit(emit),
		.free(free),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule

### design/artd_checker.sv
// ----------------------------------------------------------------------------
// artd_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "alternating_rle_table_decoder_macros.svh"

module artd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input artd_pkg::in_t in_data,
	input logic out_valid,
	input logic out_ready,
	input artd_pkg::out_t out_data
);

	// stalled output word holds
	`ARTD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
	// input is taken only when the output register can take a result
	`ARTD_ASSERT(a_ready_free, in_ready |-> (!out_valid || out_ready))
	// a restart gives no result
	`ARTD_ASSERT_NEXT(a_restart_quiet, in_valid && in_ready && in_data.action, !out_valid)
	// the word that reaches the total ends its item
	`ARTD_ASSERT(a_done_last, (out_valid && out_data.table_done) |-> out_data.last)

endmodule

bind alternating_rle_table_decoder artd_checker u_artd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.in_data(in_data),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data(out_data)
);

### dv/alternating_rle_table_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alternating_rle_table_decoder_tb
// Self-checking bench for the literal/run table decoder. A directed table
// covers the register extremes, the count corner cases and completion status.
// Random phases then send well-formed group sequences mixed with restarts and
// stray words. Every output word is compared field by field against an
// in-bench decoder model.
// ----------------------------------------------------------------------------
module alternating_rle_table_decoder_tb;

	localparam logic ACT_WORD = 1'b0;
	localparam logic ACT_RESTART = 1'b1;
	localparam int SETTLE_CYC = 8;
	localparam int HOLD_OFF_CYC = 400;
	localparam int STUCK_LIMIT = 4000;
	localparam int RAND_PHASES = 5;
	localparam int WORDS_PER_PHASE = 16;

	typedef enum logic [1:0] {ROW_CFG, ROW_WORD, ROW_DONE} row_kind_t;

	typedef logic [artd_pkg::CFG_DATA_W-1:0] cfg_val_t;

	// sel: register index for ROW_CFG, action bit otherwise
	typedef struct packed {
		row_kind_t kind;
		logic sel;
		logic [31:0] arg;
		logic [15:0] done_idx;
	} stim_row_t;

	localparam stim_row_t DIRECTED_ROWS [30] = '{
		'{ROW_DONE, ACT_WORD, 32'h0000_0005, 16'd0},          // total is 0 out of reset
		'{ROW_WORD, ACT_RESTART, 32'hFFFF_FFFF, 16'd0},
		'{ROW_CFG, artd_pkg::CFG_TOTAL_ENTRIES, 32'd20, 16'd0},
		'{ROW_CFG, artd_pkg::CFG_WORDS_PER_ELEMENT, 32'd3, 16'd0},
		'{ROW_WORD, ACT_WORD, 32'hFFFF_FFFF, 16'd0},          // negative literal count
		'{ROW_WORD, ACT_WORD, 32'h0000_0000, 16'd0},          // empty run
		'{ROW_WORD, ACT_WORD, 32'h1234_5678, 16'd0},
		'{ROW_WORD, ACT_WORD, 32'd2, 16'd0},
		'{ROW_WORD, ACT_WORD, 32'h7FFF_FFFF, 16'd0},
		'{ROW_WORD, ACT_WORD, 32'h8000_0000, 16'd0},
		'{ROW_WORD, ACT_WORD, 32'd100, 16'd0},                // clamped run
		'{ROW_WORD, ACT_WORD, 32'hFFFF_FFFF, 16'd0},          // cut short at the total
		'{ROW_DONE, ACT_WORD, 32'h0000_0000, 16'd20},
		'{ROW_WORD, ACT_RESTART, 32'h0000_0000, 16'd0},
		'{ROW_CFG, artd_pkg::CFG_TOTAL_ENTRIES, 32'h0001_FFFF, 16'd0},
		'{ROW_CFG, artd_pkg::CFG_WORDS_PER_ELEMENT, 32'd2, 16'd0},
		'{ROW_WORD, ACT_WORD, 32'd1, 16'd0},
		'{ROW_WORD, ACT_WORD, 32'h8000_0000, 16'd0},
		'{ROW_WORD, ACT_WORD, 32'h7FFF_FFFF, 16'd0},
		'{ROW_WORD, ACT_WORD, 32'd64, 16'd0},                 // longest unclamped run
		'{ROW_WORD, ACT_WORD, 32'h7FFF_FFFF, 16'd0},
		'{ROW_WORD, ACT_WORD, 32'h0000_0000, 16'd0},
		'{ROW_WORD, ACT_WORD, 32'd3, 16'd0},
		'{ROW_WORD, ACT_WORD, 32'hA5A5_A5A5, 16'd0},
		'{ROW_CFG, artd_pkg::CFG_WORDS_PER_ELEMENT, 32'd0, 16'd0}, // form drops mid-element
		'{ROW_WORD, ACT_WORD, 32'h5A5A_5A5A, 16'd0},
		'{ROW_CFG, artd_pkg::CFG_WORDS_PER_ELEMENT, 32'd2, 16'd0}, // value takes held type
		'{ROW_WORD, ACT_WORD, 32'hC0DE_0001, 16'd0},
		'{ROW_WORD, ACT_WORD, 32'h0000_0001, 16'd0},
		'{ROW_WORD, ACT_WORD, 32'h0000_0002, 16'd0}
	};

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	artd_pkg::in_t in_data;
	logic out_valid;
	logic out_ready;
	artd_pkg::out_t out_data;
	logic cfg_we;
	logic [artd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [artd_pkg::CFG_DATA_W-1:0] cfg_data;

	// decoder model state
	logic [1:0] cfg_wpe;
	logic [16:0] cfg_total;
	logic run_grp;
	logic [1:0] phase;
	logic [31:0] left_cnt;
	logic [16:0] next_idx;
	logic [31:0] type_hold;
	artd_pkg::out_t pending_entries[$];

	int sent_cnt = 0;
	int rcv_cnt = 0;
	int field_errs = 0;
	int stuck_cyc = 0;
	bit squeeze_go = 1'b0;
	bit squeezed = 1'b0;

	alternating_rle_table_decoder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [16:0] table_limit();
		return (cfg_total > artd_pkg::TABLE_DEPTH) ? artd_pkg::TABLE_DEPTH : cfg_total;
	endfunction

	task automatic clear_decode();
		run_grp = 1'b0;
		phase = artd_pkg::PH_COUNT;
		left_cnt = '0;
		next_idx = '0;
		type_hold = '0;
	endtask

	task automatic push_entry(input logic [31:0] typ, input logic [31:0] val,
			input logic [16:0] idx, input logic lst, input logic done, input logic clamped);
		artd_pkg::out_t r;
		r.entry_type = typ;
		r.entry_value = val;
		r.entry_index = (idx > 17'd65535) ? 16'hFFFF : idx[15:0];
		r.last = lst;
		r.table_done = done;
		r.run_clamped = clamped;
		pending_entries.push_back(r);
	endtask

	// Advance the model by one accepted word and queue the entries it yields.
	task automatic decode_word(input artd_pkg::in_t w);
		logic [16:0] lim;
		logic two;
		logic [1:0] elem_phase;
		logic [31:0] typ;
		logic [31:0] n;
		logic [31:0] room;
		logic clamped;
		lim = table_limit();
		two = (cfg_wpe == artd_pkg::WPE_TWO);
		elem_phase = two ? artd_pkg::PH_TYPE : artd_pkg::PH_VALUE;
		typ = two ? type_hold : 32'd0;
		if (w.action == ACT_RESTART) begin
			clear_decode();
		end else if (next_idx >= lim) begin
			push_entry(32'd0, 32'd0, next_idx, 1'b1, 1'b1, 1'b0);
		end else if (phase == artd_pkg::PH_COUNT) begin
			left_cnt = w.stream_word[31] ? 32'd0 : w.stream_word;
			if (!run_grp && left_cnt == 0)
				run_grp = 1'b1;
			else
				phase = elem_phase;
		end else if (phase == artd_pkg::PH_TYPE) begin
			type_hold = w.stream_word;
			phase = artd_pkg::PH_VALUE;
		end else if (!run_grp) begin
			push_entry(typ, w.stream_word, next_idx, 1'b1, next_idx + 1 >= lim, 1'b0);
			next_idx++;
			left_cnt--;
			if (left_cnt == 0) begin
				run_grp = 1'b1;
				phase = artd_pkg::PH_COUNT;
			end else begin
				phase = elem_phase;
			end
		end else begin
			clamped = left_cnt > artd_pkg::MAX_RUN_DEF;
			n = clamped ? artd_pkg::MAX_RUN_DEF : left_cnt;
			room = lim - next_idx;
			if (n > room)
				n = room;
			for (int k = 0; k < int'(n); k++) begin
				push_entry(typ, w.stream_word, next_idx, k == int'(n) - 1,
					next_idx + 1 >= lim, clamped);
				next_idx++;
			end
			left_cnt = '0;
			run_grp = 1'b0;
			phase = artd_pkg::PH_COUNT;
		end
	endtask

	function automatic logic [31:0] pick_count();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 8)
			return 32'd0;
		if (sel < 14)
			return $urandom | 32'h8000_0000;
		// huge counts: mostly runs, a few literals that go on to the total
		if (sel < 20 && (run_grp || sel < 16))
			return $urandom_range(32'h7FFF_FFFF, artd_pkg::MAX_RUN_DEF + 1);
		if (!run_grp || sel < 60)
			return $urandom_range(1, 4);
		return $urandom_range(5, artd_pkg::MAX_RUN_DEF + 6);
	endfunction

	// Mostly the word the decoder is waiting for, with random content.
	function automatic artd_pkg::in_t pick_word();
		artd_pkg::in_t w;
		int unsigned sel;
		w.action = ACT_WORD;
		w.stream_word = $urandom;
		sel = $urandom_range(99);
		if (next_idx >= table_limit() && sel < 70)
			w.action = ACT_RESTART;
		else if (sel < 5)
			w.action = ACT_RESTART;
		else if (sel >= 10 && phase == artd_pkg::PH_COUNT)
			w.stream_word = pick_count();
		return w;
	endfunction

	task automatic send_word(input artd_pkg::in_t w, input logic typed,
			input logic [15:0] done_idx);
		while (!(sent_cnt >= 60 && sent_cnt < 140) && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (in_ready !== 1'b1);
		sent_cnt++;
		if (typed)
			push_entry(32'd0, 32'd0, {1'b0, done_idx}, 1'b1, 1'b1, 1'b0);
		else
			decode_word(w);
	endtask

	// drop valid, let all expected words drain, then let the block go quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_entries.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input logic [artd_pkg::CFG_IDX_W-1:0] idx, input cfg_val_t val);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == artd_pkg::CFG_WORDS_PER_ELEMENT)
			cfg_wpe = val[1:0];
		else
			cfg_total = val;
	endtask

	task automatic check_field(input string fname, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			field_errs++;
			$display("%0t: %s expected %h got %h", $time, fname, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		artd_pkg::out_t exp_e;
		if (arst_n && out_valid && out_ready) begin
			rcv_cnt++;
			if (pending_entries.size() == 0) begin
				field_errs++;
				$display("%0t: expected no word, got %p", $time, out_data);
			end else begin
				exp_e = pending_entries.pop_front();
				check_field("entry_type", exp_e.entry_type, out_data.entry_type);
				check_field("entry_value", exp_e.entry_value, out_data.entry_value);
				check_field("entry_index", 32'(exp_e.entry_index), 32'(out_data.entry_index));
				check_field("last", 32'(exp_e.last), 32'(out_data.last));
				check_field("table_done", 32'(exp_e.table_done), 32'(out_data.table_done));
				check_field("run_clamped", 32'(exp_e.run_clamped),
					32'(out_data.run_clamped));
			end
		end
	end

	// output side: random stalls, one long hold-off, one stall-free stretch
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (squeeze_go && !squeezed) begin
				squeezed = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYC) @(posedge clk);
			end
			out_ready <= (rcv_cnt >= 40 && rcv_cnt < 160) || ($urandom_range(99) >= 13);
		end
	end

	// longest legal gap is the hold-off above
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stuck_cyc <= 0;
		else
			stuck_cyc <= stuck_cyc + 1;
		if (stuck_cyc >= STUCK_LIMIT) begin
			$display("alternating_rle_table_decoder_tb: FAIL");
			$finish;
		end
	end

	initial begin
		stim_row_t row;
		artd_pkg::in_t w;
		cfg_val_t tot;
		int useful;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cfg_wpe = 2'd1;
		cfg_total = '0;
		clear_decode();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
			row = DIRECTED_ROWS[i];
			w.action = row.sel;
			w.stream_word = row.arg;
			case (row.kind)
				ROW_CFG: begin
					write_reg(row.sel, row.arg[artd_pkg::CFG_DATA_W-1:0]);
				end
				ROW_WORD: begin
					send_word(w, 1'b0, '0);
				end
				default: begin
					send_word(w, 1'b1, row.done_idx);
				end
			endcase
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			write_reg(artd_pkg::CFG_WORDS_PER_ELEMENT,
				cfg_val_t'(($urandom_range(3) == 0) ? $urandom_range(3)
					: $urandom_range(1, 2)));
			case ($urandom_range(9))
				0: tot = cfg_val_t'($urandom_range(3));
				1: tot = cfg_val_t'($urandom_range(65536, 131071));
				default: tot = cfg_val_t'($urandom_range(1, 150));
			endcase
			if (ph == 1)
				tot = artd_pkg::TABLE_DEPTH;
			write_reg(artd_pkg::CFG_TOTAL_ENTRIES, tot);
			if ($urandom_range(9) < 7) begin
				w.action = ACT_RESTART;
				w.stream_word = $urandom;
				send_word(w, 1'b0, '0);
			end
			if (ph == 1)
				squeeze_go = 1'b1;
			useful = 0;
			while (useful < WORDS_PER_PHASE) begin
				w = pick_word();
				if (!(w.action == ACT_WORD && next_idx >= table_limit()))
					useful++;
				send_word(w, 1'b0, '0);
			end
		end

		settle();
		if (field_errs == 0 && pending_entries.size() == 0)
			$display("alternating_rle_table_decoder_tb: PASS");
		else
			$display("alternating_rle_table_decoder_tb: FAIL");
		$finish;
	end

endmodule
